### src/pftn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pftn_pkg
// Shared types and constants for the polygon fan triangulator.
// ----------------------------------------------------------------------------
package pftn_pkg;

    localparam int VERTEX_DEPTH   = 4096;
    localparam int COORD_BITS     = 24;
    localparam int INDEX_BITS     = 16;
    localparam int NORMAL_BITS    = 51;

    localparam int ADDR_BITS      = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
    localparam int COUNT_BITS     = $clog2(VERTEX_DEPTH + 1);
    localparam int CMP_BITS       = ((COUNT_BITS > INDEX_BITS) ? COUNT_BITS : INDEX_BITS) + 1;
    localparam int VERTEX_BITS    = 3 * COORD_BITS;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int NORM_CALC_BITS = (PROD_BITS + 1 > NORMAL_BITS) ? PROD_BITS + 1 : NORMAL_BITS;

    localparam logic [1:0] FUNC_VERTEX = 2'd0;
    localparam logic [1:0] FUNC_CORNER = 2'd1;
    localparam logic [1:0] FUNC_MESH   = 2'd2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } vertex_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SUB  = 4'b1000
    } state_t;

endpackage
`default_nettype wire

### src/pftn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pftn_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pftn_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### src/polygon_fan_triangulator_normal.sv
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_fan_triangulator_normal
// Fan triangulation of polygon faces with an unnormalized face normal.
// ----------------------------------------------------------------------------
// Usage:
//   A transfer is taken when start is high and busy is low. func selects
//   vertex store (0), face corner (1) or new mesh (2); code 3 is ignored.
//   Vertex and new-mesh items complete in the cycle they are taken, busy
//   stays low. A corner item reads the vertex RAM and keeps busy high for
//   its read state, or for the read, multiply and subtract states when it
//   closes a fan triangle: RAM read, six parallel 25x25 multipliers, subtract.
//   A triangle appears on a_*/b_*/c_*/normal_* with done high for one cycle,
//   in the cycle in which busy falls; a new item may be taken in that same cycle.
//   Throughput: one item per cycle for vertices while busy is low; a corner
//   holds busy high, so no new item is taken until it is through.
//   The receiver cannot stall; done is a single-cycle strobe.
//   Reset clears the vertex count, face state and control; RAM contents
//   are left as they are and are never used at or above the vertex count.
// ----------------------------------------------------------------------------
module polygon_fan_triangulator_normal (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire logic        [1:0]                         func,
    input  wire logic signed [pftn_pkg::COORD_BITS-1:0]    coord_x,
    input  wire logic signed [pftn_pkg::COORD_BITS-1:0]    coord_y,
    input  wire logic signed [pftn_pkg::COORD_BITS-1:0]    coord_z,
    input  wire logic signed [pftn_pkg::INDEX_BITS-1:0]    corner_index,
    input  wire logic                                      face_start,
    output logic                                           done,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         a_x,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         a_y,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         a_z,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         b_x,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         b_y,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         b_z,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         c_x,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         c_y,
    output logic signed [pftn_pkg::COORD_BITS-1:0]         c_z,
    output logic signed [pftn_pkg::NORMAL_BITS-1:0]        normal_x,
    output logic signed [pftn_pkg::NORMAL_BITS-1:0]        normal_y,
    output logic signed [pftn_pkg::NORMAL_BITS-1:0]        normal_z
);

    localparam int DB = pftn_pkg::DIFF_BITS;
    localparam int PB = pftn_pkg::PROD_BITS;
    localparam int NB = pftn_pkg::NORM_CALC_BITS;

    pftn_pkg::state_t state_reg, state_next;

    logic [pftn_pkg::COUNT_BITS-1:0] vertex_count_reg, vertex_count_next;
    logic [1:0]                      corners_seen_reg, corners_seen_next;
    logic                            first_valid_reg, first_valid_next;
    logic                            prev_valid_reg, prev_valid_next;
    pftn_pkg::vertex_t               first_vertex_reg, first_vertex_next;
    pftn_pkg::vertex_t               prev_vertex_reg, prev_vertex_next;
    logic                            cur_valid_reg, cur_valid_next;
    logic                            face_start_reg, face_start_next;
    logic                            done_reg, done_next;

    pftn_pkg::vertex_t               tri_a_reg, tri_b_reg, tri_c_reg;
    logic signed [DB-1:0]            dx1_reg, dy1_reg, dz1_reg;
    logic signed [DB-1:0]            dx2_reg, dy2_reg, dz2_reg;
    logic signed [PB-1:0]            pxa_reg, pxb_reg, pya_reg, pyb_reg, pza_reg, pzb_reg;
    logic signed [pftn_pkg::NORMAL_BITS-1:0] nx_reg, ny_reg, nz_reg;

    logic                            accept;
    logic [pftn_pkg::CMP_BITS-1:0]   idx_wide;
    logic [pftn_pkg::CMP_BITS-1:0]   count_wide;
    logic                            idx_valid;
    logic                            ram_wr_en;
    logic [pftn_pkg::VERTEX_BITS-1:0] ram_rd_data;
    pftn_pkg::vertex_t               cur_vertex;
    logic                            opens;
    logic                            emit;
    logic [NB-1:0]                   nx_wide, ny_wide, nz_wide;

    assign accept = start && (state_reg == pftn_pkg::ST_IDLE);
    assign busy   = (state_reg != pftn_pkg::ST_IDLE);

    assign idx_wide   = {{(pftn_pkg::CMP_BITS - pftn_pkg::INDEX_BITS){corner_index[pftn_pkg::INDEX_BITS-1]}},
                         corner_index} - {{(pftn_pkg::CMP_BITS - 1){1'b0}}, 1'b1};
    assign count_wide = {{(pftn_pkg::CMP_BITS - pftn_pkg::COUNT_BITS){1'b0}}, vertex_count_reg};
    assign idx_valid  = !idx_wide[pftn_pkg::CMP_BITS-1] && (idx_wide < count_wide);

    assign ram_wr_en = accept && (func == pftn_pkg::FUNC_VERTEX)
                       && (count_wide < pftn_pkg::CMP_BITS'(pftn_pkg::VERTEX_DEPTH));

    pftn_ram #(
        .WIDTH (pftn_pkg::VERTEX_BITS),
        .DEPTH (pftn_pkg::VERTEX_DEPTH)
    ) u_vertex_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (vertex_count_reg[pftn_pkg::ADDR_BITS-1:0]),
        .wr_data ({coord_x, coord_y, coord_z}),
        .rd_addr (idx_wide[pftn_pkg::ADDR_BITS-1:0]),
        .rd_data (ram_rd_data)
    );

    // invalid corners count as zero
    assign cur_vertex = cur_valid_reg ? pftn_pkg::vertex_t'(ram_rd_data) : '0;
    assign opens      = face_start_reg || (corners_seen_reg == 2'd0);
    assign emit       = !opens && (corners_seen_reg == 2'd2) && first_valid_reg
                        && prev_valid_reg && cur_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        vertex_count_next = vertex_count_reg;
        corners_seen_next = corners_seen_reg;
        first_valid_next  = first_valid_reg;
        prev_valid_next   = prev_valid_reg;
        first_vertex_next = first_vertex_reg;
        prev_vertex_next  = prev_vertex_reg;
        cur_valid_next    = cur_valid_reg;
        face_start_next   = face_start_reg;
        done_next         = 1'b0;

        unique case (state_reg)
            pftn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func)
                        pftn_pkg::FUNC_VERTEX:
                        begin
                            if (ram_wr_en)
                            begin
                                vertex_count_next = vertex_count_reg + 1'b1;
                            end
                        end
                        pftn_pkg::FUNC_CORNER:
                        begin
                            cur_valid_next  = idx_valid;
                            face_start_next = face_start;
                            state_next      = pftn_pkg::ST_READ;
                        end
                        pftn_pkg::FUNC_MESH:
                        begin
                            vertex_count_next = '0;
                            corners_seen_next = 2'd0;
                            first_valid_next  = 1'b0;
                            prev_valid_next   = 1'b0;
                            first_vertex_next = '0;
                            prev_vertex_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pftn_pkg::ST_READ:
            begin
                prev_vertex_next  = cur_vertex;
                prev_valid_next   = cur_valid_reg;
                if (opens)
                begin
                    first_vertex_next = cur_vertex;
                    first_valid_next  = cur_valid_reg;
                    corners_seen_next = 2'd1;
                end
                else
                begin
                    corners_seen_next = 2'd2;
                end
                state_next = emit ? pftn_pkg::ST_MUL : pftn_pkg::ST_IDLE;
            end
            pftn_pkg::ST_MUL:
            begin
                state_next = pftn_pkg::ST_SUB;
            end
            pftn_pkg::ST_SUB:
            begin
                done_next  = 1'b1;
                state_next = pftn_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pftn_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pftn_pkg::ST_IDLE;
            vertex_count_reg <= '0;
            corners_seen_reg <= 2'd0;
            first_valid_reg  <= 1'b0;
            prev_valid_reg   <= 1'b0;
            cur_valid_reg    <= 1'b0;
            face_start_reg   <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            vertex_count_reg <= vertex_count_next;
            corners_seen_reg <= corners_seen_next;
            first_valid_reg  <= first_valid_next;
            prev_valid_reg   <= prev_valid_next;
            cur_valid_reg    <= cur_valid_next;
            face_start_reg   <= face_start_next;
            done_reg         <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_vertex_reg <= first_vertex_next;
        prev_vertex_reg  <= prev_vertex_next;
    end

    // datapath: capture + differences, products, final subtract
    always_ff @(posedge clk)
    begin
        if (state_reg == pftn_pkg::ST_READ)
        begin
            tri_a_reg <= first_vertex_reg;
            tri_b_reg <= prev_vertex_reg;
            tri_c_reg <= cur_vertex;
            dx1_reg <= {prev_vertex_reg.x[pftn_pkg::COORD_BITS-1], prev_vertex_reg.x}
                     - {first_vertex_reg.x[pftn_pkg::COORD_BITS-1], first_vertex_reg.x};
            dy1_reg <= {prev_vertex_reg.y[pftn_pkg::COORD_BITS-1], prev_vertex_reg.y}
                     - {first_vertex_reg.y[pftn_pkg::COORD_BITS-1], first_vertex_reg.y};
            dz1_reg <= {prev_vertex_reg.z[pftn_pkg::COORD_BITS-1], prev_vertex_reg.z}
                     - {first_vertex_reg.z[pftn_pkg::COORD_BITS-1], first_vertex_reg.z};
            dx2_reg <= {cur_vertex.x[pftn_pkg::COORD_BITS-1], cur_vertex.x}
                     - {first_vertex_reg.x[pftn_pkg::COORD_BITS-1], first_vertex_reg.x};
            dy2_reg <= {cur_vertex.y[pftn_pkg::COORD_BITS-1], cur_vertex.y}
                     - {first_vertex_reg.y[pftn_pkg::COORD_BITS-1], first_vertex_reg.y};
            dz2_reg <= {cur_vertex.z[pftn_pkg::COORD_BITS-1], cur_vertex.z}
                     - {first_vertex_reg.z[pftn_pkg::COORD_BITS-1], first_vertex_reg.z};
        end
        if (state_reg == pftn_pkg::ST_MUL)
        begin
            pxa_reg <= $signed({{DB{dy1_reg[DB-1]}}, dy1_reg}) * $signed({{DB{dz2_reg[DB-1]}}, dz2_reg});
            pxb_reg <= $signed({{DB{dz1_reg[DB-1]}}, dz1_reg}) * $signed({{DB{dy2_reg[DB-1]}}, dy2_reg});
            pya_reg <= $signed({{DB{dz1_reg[DB-1]}}, dz1_reg}) * $signed({{DB{dx2_reg[DB-1]}}, dx2_reg});
            pyb_reg <= $signed({{DB{dx1_reg[DB-1]}}, dx1_reg}) * $signed({{DB{dz2_reg[DB-1]}}, dz2_reg});
            pza_reg <= $signed({{DB{dx1_reg[DB-1]}}, dx1_reg}) * $signed({{DB{dy2_reg[DB-1]}}, dy2_reg});
            pzb_reg <= $signed({{DB{dy1_reg[DB-1]}}, dy1_reg}) * $signed({{DB{dx2_reg[DB-1]}}, dx2_reg});
        end
        if (state_reg == pftn_pkg::ST_SUB)
        begin
            nx_reg <= nx_wide[pftn_pkg::NORMAL_BITS-1:0];
            ny_reg <= ny_wide[pftn_pkg::NORMAL_BITS-1:0];
            nz_reg <= nz_wide[pftn_pkg::NORMAL_BITS-1:0];
        end
    end

    assign nx_wide = {{(NB - PB){pxa_reg[PB-1]}}, pxa_reg} - {{(NB - PB){pxb_reg[PB-1]}}, pxb_reg};
    assign ny_wide = {{(NB - PB){pya_reg[PB-1]}}, pya_reg} - {{(NB - PB){pyb_reg[PB-1]}}, pyb_reg};
    assign nz_wide = {{(NB - PB){pza_reg[PB-1]}}, pza_reg} - {{(NB - PB){pzb_reg[PB-1]}}, pzb_reg};

    assign done     = done_reg;
    assign a_x      = tri_a_reg.x;
    assign a_y      = tri_a_reg.y;
    assign a_z      = tri_a_reg.z;
    assign b_x      = tri_b_reg.x;
    assign b_y      = tri_b_reg.y;
    assign b_z      = tri_b_reg.z;
    assign c_x      = tri_c_reg.x;
    assign c_y      = tri_c_reg.y;
    assign c_z      = tri_c_reg.z;
    assign normal_x = nx_reg;
    assign normal_y = ny_reg;
    assign normal_z = nz_reg;

`ifndef SYNTH
    a_sub_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pftn_pkg::ST_SUB) |=> done_reg)
        else $error("triangle not delivered after subtract stage");

    a_mul_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pftn_pkg::ST_MUL) |-> $past(state_reg == pftn_pkg::ST_READ))
        else $error("multiply stage entered without a RAM read");

    a_done_face_state: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (corners_seen_reg == 2'd2) && first_valid_reg)
        else $error("triangle emitted without an open valid fan");

    a_mesh_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == pftn_pkg::FUNC_MESH)) |=>
            (vertex_count_reg == '0) && (corners_seen_reg == 2'd0))
        else $error("new mesh did not clear vertex count and face");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |=> (vertex_count_reg == $past(vertex_count_reg) + 1'b1))
        else $error("vertex count did not advance on store");
`endif

endmodule
`default_nettype wire

### bench/polygon_fan_triangulator_normal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_triangulator_normal_checker
// Watches the command and result ports of the fan triangulator and keeps its
// own copy of the vertex store and fan state. Every accepted corner that
// closes a triangle of stored vertices queues the expected triangle and
// normal. Each done strobe is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module polygon_fan_triangulator_normal_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic [1:0]                              func,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  coord_x,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  coord_y,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  coord_z,
    input  logic signed [pftn_pkg::INDEX_BITS-1:0]  corner_index,
    input  logic                                    face_start,
    input  logic                                    done,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  a_x,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  a_y,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  a_z,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  b_x,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  b_y,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  b_z,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  c_x,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  c_y,
    input  logic signed [pftn_pkg::COORD_BITS-1:0]  c_z,
    input  logic signed [pftn_pkg::NORMAL_BITS-1:0] normal_x,
    input  logic signed [pftn_pkg::NORMAL_BITS-1:0] normal_y,
    input  logic signed [pftn_pkg::NORMAL_BITS-1:0] normal_z,
    output int                                      errors,
    output int                                      pending
);

    typedef struct {
        pftn_pkg::vertex_t                       a;
        pftn_pkg::vertex_t                       b;
        pftn_pkg::vertex_t                       c;
        logic signed [pftn_pkg::NORMAL_BITS-1:0] nx;
        logic signed [pftn_pkg::NORMAL_BITS-1:0] ny;
        logic signed [pftn_pkg::NORMAL_BITS-1:0] nz;
    } triangle_t;

    pftn_pkg::vertex_t vertices [pftn_pkg::VERTEX_DEPTH];
    int                vertices_held;
    pftn_pkg::vertex_t first_corner;
    pftn_pkg::vertex_t prev_corner;
    bit                first_ok;
    bit                prev_ok;
    int                corners;
    triangle_t         triangles_due [$];
    int                mismatches = 0;
    int                due = 0;

    assign errors  = mismatches;
    assign pending = due;

    task automatic report(input string msg);
        if (mismatches < 100)
            $display("%0t checker: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got !== want)
            report($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic logic signed [pftn_pkg::NORMAL_BITS-1:0] cross_term(
        input longint p, input longint q, input longint r, input longint s);
        return pftn_pkg::NORMAL_BITS'(p * q - r * s);
    endfunction

    function automatic longint coord(input logic signed [pftn_pkg::COORD_BITS-1:0] v);
        return longint'(v);
    endfunction

    task automatic clear_fan();
        first_corner = '0;
        prev_corner  = '0;
        first_ok     = 1'b0;
        prev_ok      = 1'b0;
        corners      = 0;
    endtask

    // one accepted command: update the model state, queue a triangle if due
    task automatic fan_step();
        pftn_pkg::vertex_t cur;
        bit                cur_ok;
        int                idx;
        triangle_t         t;
        longint            dx1, dy1, dz1, dx2, dy2, dz2;
        case (func)
            pftn_pkg::FUNC_VERTEX:
                if (vertices_held < pftn_pkg::VERTEX_DEPTH) begin
                    vertices[vertices_held] = {coord_x, coord_y, coord_z};
                    vertices_held++;
                end
            pftn_pkg::FUNC_MESH:
            begin
                vertices_held = 0;
                clear_fan();
            end
            pftn_pkg::FUNC_CORNER:
            begin
                idx    = int'(corner_index) - 1;
                cur_ok = (idx >= 0) && (idx < vertices_held);
                cur    = cur_ok ? vertices[idx] : '0;
                if (face_start || corners == 0) begin
                    first_corner = cur;
                    first_ok     = cur_ok;
                    prev_corner  = cur;
                    prev_ok      = cur_ok;
                    corners      = 1;
                end
                else begin
                    if (corners == 2 && first_ok && prev_ok && cur_ok) begin
                        dx1  = coord(prev_corner.x) - coord(first_corner.x);
                        dy1  = coord(prev_corner.y) - coord(first_corner.y);
                        dz1  = coord(prev_corner.z) - coord(first_corner.z);
                        dx2  = coord(cur.x) - coord(first_corner.x);
                        dy2  = coord(cur.y) - coord(first_corner.y);
                        dz2  = coord(cur.z) - coord(first_corner.z);
                        t.a  = first_corner;
                        t.b  = prev_corner;
                        t.c  = cur;
                        t.nx = cross_term(dy1, dz2, dz1, dy2);
                        t.ny = cross_term(dz1, dx2, dx1, dz2);
                        t.nz = cross_term(dx1, dy2, dy1, dx2);
                        triangles_due = {triangles_due, t};
                    end
                    prev_corner = cur;
                    prev_ok     = cur_ok;
                    corners     = 2;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        triangle_t want;
        if (!rst_n) begin
            vertices_held = 0;
            clear_fan();
            triangles_due.delete();
            due <= 0;
        end
        else begin
            if (done) begin
                if (triangles_due.size() == 0) begin
                    report("triangle transfer with none pending");
                end
                else begin
                    want = triangles_due.pop_front();
                    check_field("a_x", coord(a_x), coord(want.a.x));
                    check_field("a_y", coord(a_y), coord(want.a.y));
                    check_field("a_z", coord(a_z), coord(want.a.z));
                    check_field("b_x", coord(b_x), coord(want.b.x));
                    check_field("b_y", coord(b_y), coord(want.b.y));
                    check_field("b_z", coord(b_z), coord(want.b.z));
                    check_field("c_x", coord(c_x), coord(want.c.x));
                    check_field("c_y", coord(c_y), coord(want.c.y));
                    check_field("c_z", coord(c_z), coord(want.c.z));
                    check_field("normal_x", longint'(normal_x), longint'(want.nx));
                    check_field("normal_y", longint'(normal_y), longint'(want.ny));
                    check_field("normal_z", longint'(normal_z), longint'(want.nz));
                end
            end
            if (start && !busy)
                fan_step();
            due <= triangles_due.size();
        end
    end

endmodule

### bench/polygon_fan_triangulator_normal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_fan_triangulator_normal_tb
// Drives vertex, corner and new-mesh commands into the fan triangulator:
// a directed pass over coordinate and index extremes, invalid corners, a
// full vertex store, then random meshes under varying sender idle rates.
// The checker beside the block predicts and compares the triangles.
// ----------------------------------------------------------------------------
module polygon_fan_triangulator_normal_tb;

    localparam int         CB           = pftn_pkg::COORD_BITS;
    localparam int         IB           = pftn_pkg::INDEX_BITS;
    localparam int         LIMIT        = 400000;
    localparam int         RANDOM_ITEMS = 1550;
    localparam logic [1:0] FUNC_UNUSED  = 2'd3;
    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    start = 1'b0;
    logic                                    busy;
    logic [1:0]                              func = pftn_pkg::FUNC_VERTEX;
    logic signed [CB-1:0]                    coord_x = '0;
    logic signed [CB-1:0]                    coord_y = '0;
    logic signed [CB-1:0]                    coord_z = '0;
    logic signed [IB-1:0]                    corner_index = '0;
    logic                                    face_start = 1'b0;
    logic                                    done;
    logic signed [CB-1:0]                    a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic signed [pftn_pkg::NORMAL_BITS-1:0] normal_x, normal_y, normal_z;

    int fail_count;
    int pending_count;
    int cycles = 0;
    int sent = 0;
    int idle_pct = 0;
    int vertices_held = 0;
    int phase_end;

    polygon_fan_triangulator_normal dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .corner_index(corner_index), .face_start(face_start), .done(done),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
    );

    polygon_fan_triangulator_normal_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .corner_index(corner_index), .face_start(face_start), .done(done),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .errors(fail_count), .pending(pending_count)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("polygon_fan_triangulator_normal_tb failed");
            $finish;
        end
    end

    function automatic logic signed [CB-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return CB'(int'($urandom_range(0, 2047)) - 1024);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic logic signed [IB-1:0] rand_index();
        if (vertices_held > 0 && $urandom_range(1, 100) <= 85)
            return IB'($urandom_range(1, vertices_held));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return IB'(vertices_held + 1);
            2:       return IB'(-int'($urandom_range(1, 32768)));
            default: return IB'($urandom);
        endcase
    endfunction

    // one command transfer, with an optional idle gap in front
    task automatic transfer(input logic [1:0] f, input logic signed [CB-1:0] x,
                            input logic signed [CB-1:0] y,
                            input logic signed [CB-1:0] z,
                            input logic signed [IB-1:0] idx, input logic fs);
        int gap;
        gap = ($urandom_range(1, 100) <= idle_pct) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        func         <= f;
        coord_x      <= x;
        coord_y      <= y;
        coord_z      <= z;
        corner_index <= idx;
        face_start   <= fs;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (f != FUNC_UNUSED)
            sent++;
        if (f == pftn_pkg::FUNC_VERTEX && vertices_held < pftn_pkg::VERTEX_DEPTH)
            vertices_held++;
        if (f == pftn_pkg::FUNC_MESH)
            vertices_held = 0;
    endtask

    task automatic add_vertex(input logic signed [CB-1:0] x,
                              input logic signed [CB-1:0] y,
                              input logic signed [CB-1:0] z);
        transfer(pftn_pkg::FUNC_VERTEX, x, y, z, IB'($urandom), 1'($urandom));
    endtask

    task automatic corner(input logic signed [IB-1:0] idx, input logic fs);
        transfer(pftn_pkg::FUNC_CORNER, rand_coord(), rand_coord(), rand_coord(), idx, fs);
    endtask

    task automatic new_mesh();
        transfer(pftn_pkg::FUNC_MESH, rand_coord(), rand_coord(), rand_coord(),
                 IB'($urandom), 1'($urandom));
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    // a few vertices, then faces with mostly valid corners
    task automatic random_mesh();
        int nv, nf, nc;
        if ($urandom_range(1, 4) == 1)
            new_mesh();
        nv = $urandom_range(0, 8);
        repeat (nv) add_vertex(rand_coord(), rand_coord(), rand_coord());
        nf = $urandom_range(1, 4);
        repeat (nf) begin
            nc = $urandom_range(1, 7);
            corner(rand_index(), $urandom_range(1, 8) != 1);
            repeat (nc - 1) corner(rand_index(), $urandom_range(1, 16) == 1);
        end
        if ($urandom_range(1, 20) == 1)
            transfer(FUNC_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                     IB'($urandom), 1'($urandom));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 10;

        // corner without face start and no vertices: opens an invalid face
        corner(IB'(1), 1'b0);
        add_vertex(C_MAX, C_MAX, C_MAX);
        add_vertex(C_MIN, C_MIN, C_MIN);
        add_vertex(C_MAX, C_MIN, '0);
        add_vertex(C_MIN, C_MAX, C_MAX);
        corner(IB'(1), 1'b1);
        corner(IB'(2), 1'b0);
        corner(IB'(3), 1'b0);
        corner(IB'(4), 1'b0);
        corner(IB'(0), 1'b0);
        corner(IB'(2), 1'b0);
        corner(IB'(3), 1'b0);
        corner(IB'(-32768), 1'b1);
        corner(IB'(1), 1'b0);
        corner(IB'(2), 1'b0);
        corner(IB'(32767), 1'b1);
        transfer(FUNC_UNUSED, C_MAX, C_MIN, C_MAX, IB'(1), 1'b1);
        // corner 5 is invalid when it arrives and stays so
        corner(IB'(5), 1'b1);
        add_vertex(C_MIN, '0, C_MAX);
        corner(IB'(1), 1'b0);
        corner(IB'(2), 1'b0);
        new_mesh();
        corner(IB'(1), 1'b0);

        // full store: the last vertex is dropped
        new_mesh();
        repeat (pftn_pkg::VERTEX_DEPTH + 1) add_vertex(rand_coord(), rand_coord(), rand_coord());
        corner(IB'(pftn_pkg::VERTEX_DEPTH), 1'b1);
        corner(IB'(1), 1'b0);
        corner(IB'(2), 1'b0);
        corner(IB'(pftn_pkg::VERTEX_DEPTH + 1), 1'b0);
        corner(IB'(3), 1'b0);
        corner(IB'(4), 1'b0);
        new_mesh();

        for (int phase = 0; phase < 3; phase++) begin
            idle_pct  = (phase == 0) ? 25 : (phase == 1) ? 69 : 0;
            phase_end = sent + RANDOM_ITEMS / 3;
            while (sent < phase_end) random_mesh();
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("polygon_fan_triangulator_normal_tb passed");
        else
            $display("polygon_fan_triangulator_normal_tb failed");
        $finish;
    end

endmodule

### sim.f
src/pftn_pkg.sv
src/pftn_ram.sv
src/polygon_fan_triangulator_normal.sv
bench/polygon_fan_triangulator_normal_checker.sv
bench/polygon_fan_triangulator_normal_tb.sv
